### rtl/iirtdf2_pkg.sv
// types and constants for the transposed direct form ii iir filter
// no dependencies; imported by iir_filter_transposed_df2

package iirtdf2_pkg;

   // filter order and field widths
   localparam int ORDER    = 3;
   localparam int NUM_CSR  = 7;
   localparam int CSR_W    = 3;
   localparam int COEF_W   = 16;
   localparam int SAMPLE_W = 16;
   localparam int OP_W     = 2;
   localparam int IDX_W    = 2;
   localparam int DELAY_W  = 40;
   localparam int FRAC_W   = 14;
   localparam int PROD_W   = COEF_W + SAMPLE_W;
   localparam int ACC_W    = DELAY_W + 1;
   localparam int DIFF_W   = DELAY_W + 2;

   // register indexes
   localparam logic [CSR_W-1:0] CSR_FF0 = CSR_W'(0);
   localparam logic [CSR_W-1:0] CSR_FB1 = CSR_W'(4);

   // b0 resets to 1.0 in q2.14
   localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1 << FRAC_W);

   // rounding and saturation limits
   localparam logic signed [DIFF_W-1:0] ROUND_HALF = DIFF_W'(1 << (FRAC_W - 1));
   localparam logic signed [DIFF_W-1:0] Y_MAX = DIFF_W'((1 << (SAMPLE_W - 1)) - 1);
   localparam logic signed [DIFF_W-1:0] Y_MIN = -DIFF_W'(1 << (SAMPLE_W - 1));
   localparam logic signed [DIFF_W-1:0] D_MAX = (DIFF_W'(1) <<< (DELAY_W - 1)) - DIFF_W'(1);
   localparam logic signed [DIFF_W-1:0] D_MIN = -(DIFF_W'(1) <<< (DELAY_W - 1));

   typedef enum logic [OP_W-1:0] {
      OP_FILTER = 2'd0,
      OP_WRITE  = 2'd1,
      OP_READ   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL0,
      S_OUT_Y,
      S_TAP_A,
      S_TAP_W,
      S_DONE
   } state_type;

endpackage

### rtl/iir_filter_transposed_df2.sv
// single-channel iir filter, transposed direct form ii, one shared multiplier
// depends on iirtdf2_pkg
//
// usage:
//   requests arrive on req_* with valid/stall; req_op selects filter a sample,
//   load a delay register or read a delay register back.
//   results leave on rsp_* with valid/stall: one per filter or read request,
//   none for a load or for the unused op code.
//   coefficients are written through csr_write_en/csr_index/csr_wdata; the
//   user must write them only while the block is idle, which the block does
//   not enforce. b0..b3 sit at indexes 0..3, a1..a3 at 4..6.
//   a filter request is accepted in S_IDLE; then S_MUL0 forms b0*x, S_OUT_Y
//   rounds y, and S_TAP_A and S_TAP_W take each delay register in turn as the
//   single 16x16 multiplier forms b*x and a*y; S_DONE loads the result
//   register. a read request goes from S_IDLE straight to S_DONE; a load takes
//   effect at once. req_stall is high for the whole of a request's work, so
//   a new request is taken only once the block is back in S_IDLE.
// reset clears the delay line, sets b0 to 1.0 and all other coefficients to
// zero. while rsp_stall holds a result, the next finished result waits in
// the block and req_stall stays high.

module iir_filter_transposed_df2
   import iirtdf2_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [OP_W-1:0]            req_op,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic [IDX_W-1:0]           req_state_index,
   input  logic signed [DELAY_W-1:0]  req_state_value,
   // result channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_filtered,
   output logic                       rsp_saturated,
   output logic                       rsp_is_state_read,
   output logic signed [DELAY_W-1:0]  rsp_state_read,
   // coefficient port
   input  logic                       csr_write_en,
   input  logic [CSR_W-1:0]           csr_index,
   input  logic [COEF_W-1:0]          csr_wdata
);

   state_type                   state_ff, state_in;
   logic [IDX_W-1:0]            tap_ff, tap_in;
   logic signed [COEF_W-1:0]    coef_ff [NUM_CSR];
   logic signed [DELAY_W-1:0]   delay_ff [ORDER];
   logic signed [SAMPLE_W-1:0]  x_ff;
   logic signed [SAMPLE_W-1:0]  y_ff;
   logic                        sat_ff;
   logic                        is_read_ff;
   logic signed [DELAY_W-1:0]   read_ff;
   logic signed [PROD_W-1:0]    prod_ff;
   logic signed [ACC_W-1:0]     acc_ff;
   logic                        rsp_valid_ff;
   logic signed [SAMPLE_W-1:0]  rsp_filtered_ff;
   logic                        rsp_saturated_ff;
   logic                        rsp_is_read_ff;
   logic signed [DELAY_W-1:0]   rsp_read_ff;

   logic [CSR_W-1:0]            coef_sel;
   logic                        mul_use_y;
   logic signed [COEF_W-1:0]    mul_a;
   logic signed [SAMPLE_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]    mul_p;
   logic [IDX_W-1:0]            rd_addr;
   logic signed [DELAY_W-1:0]   rd_data;
   logic signed [ACC_W-1:0]     y_acc;
   logic signed [DIFF_W-1:0]    y_q;
   logic signed [SAMPLE_W-1:0]  y_sat;
   logic                        y_clip;
   logic signed [ACC_W-1:0]     tap_sum;
   logic signed [DIFF_W-1:0]    tap_diff;
   logic signed [DELAY_W-1:0]   d_sat;
   logic                        req_accept;
   logic                        rsp_load;

   // sequencer: next state, multiplier operand selection, request stall
   always_comb begin
      state_in  = state_ff;
      tap_in    = tap_ff;
      req_stall = 1'b1;
      coef_sel  = CSR_FF0;
      mul_use_y = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               case (op_type'(req_op))
                  OP_FILTER: state_in = S_MUL0;
                  OP_READ:   state_in = S_DONE;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_MUL0: begin
            coef_sel = CSR_FF0;
            state_in = S_OUT_Y;
         end
         S_OUT_Y: begin
            // first feedforward product of the delay update
            coef_sel = CSR_FF0 + CSR_W'(1);
            state_in = S_TAP_A;
         end
         S_TAP_A: begin
            coef_sel  = CSR_FB1 + CSR_W'(tap_ff);
            mul_use_y = 1'b1;
            state_in  = S_TAP_W;
         end
         S_TAP_W: begin
            if (tap_ff == IDX_W'(ORDER - 1)) begin
               tap_in   = '0;
               state_in = S_DONE;
            end else begin
               tap_in   = tap_ff + IDX_W'(1);
               coef_sel = CSR_FF0 + CSR_W'(tap_ff) + CSR_W'(2);
               state_in = S_TAP_A;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_accept = req_valid & ~req_stall;
   assign rsp_load   = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   // shared multiplier
   assign mul_a = coef_ff[coef_sel];
   assign mul_b = mul_use_y ? y_ff : x_ff;
   assign mul_p = mul_a * mul_b;

   // delay line read port: request index when idle, register above the tap otherwise
   always_comb begin
      rd_addr = (state_ff == S_IDLE) ? req_state_index : tap_ff + IDX_W'(1);
      rd_data = '0;
      if (rd_addr < IDX_W'(ORDER)) begin
         rd_data = delay_ff[rd_addr];
      end
   end

   // output sample: round half up, then clip to 16 bits
   always_comb begin
      y_acc  = ACC_W'(delay_ff[0]) + ACC_W'(prod_ff);
      y_q    = (DIFF_W'(y_acc) + ROUND_HALF) >>> FRAC_W;
      y_sat  = y_q[SAMPLE_W-1:0];
      y_clip = 1'b0;
      if (y_q > Y_MAX) begin
         y_sat  = Y_MAX[SAMPLE_W-1:0];
         y_clip = 1'b1;
      end else if (y_q < Y_MIN) begin
         y_sat  = Y_MIN[SAMPLE_W-1:0];
         y_clip = 1'b1;
      end
   end

   // delay update: add feedforward term, subtract feedback term, clip to 40 bits
   always_comb begin
      tap_sum  = ACC_W'(rd_data) + ACC_W'(prod_ff);
      tap_diff = DIFF_W'(acc_ff) - DIFF_W'(prod_ff);
      d_sat    = tap_diff[DELAY_W-1:0];
      if (tap_diff > D_MAX) begin
         d_sat = D_MAX[DELAY_W-1:0];
      end else if (tap_diff < D_MIN) begin
         d_sat = D_MIN[DELAY_W-1:0];
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tap_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CSR; i++) begin
            coef_ff[i] <= (i == int'(CSR_FF0)) ? COEF_ONE : '0;
         end
         for (int i = 0; i < ORDER; i++) begin
            delay_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         tap_ff   <= tap_in;
         prod_ff  <= mul_p;

         // coefficient writes
         if (csr_write_en && (csr_index < CSR_W'(NUM_CSR))) begin
            coef_ff[csr_index] <= csr_wdata;
         end

         // request capture
         if (req_accept) begin
            x_ff <= req_sample;
            case (op_type'(req_op))
               OP_FILTER: begin
                  is_read_ff <= 1'b0;
                  read_ff    <= '0;
               end
               OP_WRITE: begin
                  if (req_state_index < IDX_W'(ORDER)) begin
                     delay_ff[req_state_index] <= req_state_value;
                  end
               end
               OP_READ: begin
                  is_read_ff <= 1'b1;
                  read_ff    <= rd_data;
                  y_ff       <= '0;
                  sat_ff     <= 1'b0;
               end
               default: begin
               end
            endcase
         end

         // datapath steps
         case (state_ff)
            S_OUT_Y: begin
               y_ff   <= y_sat;
               sat_ff <= y_clip;
            end
            S_TAP_A: begin
               acc_ff <= tap_sum;
            end
            S_TAP_W: begin
               delay_ff[tap_ff] <= d_sat;
            end
            default: begin
            end
         endcase

         // result register
         if (rsp_load) begin
            rsp_valid_ff     <= 1'b1;
            rsp_filtered_ff  <= y_ff;
            rsp_saturated_ff <= sat_ff;
            rsp_is_read_ff   <= is_read_ff;
            rsp_read_ff      <= read_ff;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_filtered      = rsp_filtered_ff;
   assign rsp_saturated     = rsp_saturated_ff;
   assign rsp_is_state_read = rsp_is_read_ff;
   assign rsp_state_read    = rsp_read_ff;

   // tap counter never points past the last delay register
   a_tap_range: assert property (@(posedge clock) disable iff (reset)
      tap_ff < IDX_W'(ORDER))
      else $error("tap counter out of range");

   // the last tap update always leads to the result stage
   a_last_tap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TAP_W && tap_ff == IDX_W'(ORDER - 1)) |=> state_ff == S_DONE)
      else $error("sequencer skipped result stage");

   // a finished result waits while the previous one is held
   a_done_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_valid_ff && rsp_stall) |=> state_ff == S_DONE)
      else $error("result dropped under stall");

   // a read result carries no output sample
   a_read_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_is_read_ff) |-> (rsp_filtered_ff == '0 && !rsp_saturated_ff))
      else $error("read result carries sample data");

   // a filter result carries no delay register contents
   a_filter_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_is_read_ff) |-> rsp_read_ff == '0)
      else $error("filter result carries read data");

endmodule

### tb/tb.sv
// self-checking testbench for the transposed direct form ii iir filter
// drives requests and coefficient writes, stalls results, checks each result
// by a fixed-point model here or a typed row; depends on iirtdf2_pkg and rtl

module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import iirtdf2_pkg::*;

   localparam int WIDE_W = 48;
   localparam int DRAIN_CYCLES = 16;
   localparam int PHASES = 6;
   localparam int ITEMS_PER_PHASE = 65;
   localparam int DIRECTED_ROWS = 25;
   localparam int MAX_PRINTED = 60;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_TOP = 16'sh7fff;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_BOTTOM = 16'sh8000;
   localparam logic signed [DELAY_W-1:0] DELAY_TOP = {1'b0, {(DELAY_W-1){1'b1}}};
   localparam logic signed [DELAY_W-1:0] DELAY_BOTTOM = {1'b1, {(DELAY_W-1){1'b0}}};

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] filtered;
      logic                       saturated;
      logic                       is_state_read;
      logic signed [DELAY_W-1:0]  state_read;
   } result_type;

   typedef struct {
      op_type                     op;
      logic signed [SAMPLE_W-1:0] sample;
      logic [IDX_W-1:0]           index;
      logic signed [DELAY_W-1:0]  value;
      bit                         typed;
      result_type                 result;
   } dir_row_type;

   typedef enum int {
      SET_FIR,
      SET_GENTLE,
      SET_EXTREME,
      SET_RANDOM,
      SET_CORNER,
      SET_NO_DIRECT
   } coef_set_type;

   typedef enum int {
      STALL_NEVER,
      STALL_COIN,
      STALL_LONG
   } stall_mode_type;

   // dut signals, all inputs known from time zero
   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [OP_W-1:0]            req_op = OP_NONE;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic [IDX_W-1:0]           req_state_index = '0;
   logic signed [DELAY_W-1:0]  req_state_value = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_filtered;
   logic                       rsp_saturated;
   logic                       rsp_is_state_read;
   logic signed [DELAY_W-1:0]  rsp_state_read;
   logic                       csr_write_en = 1'b0;
   logic [CSR_W-1:0]           csr_index = '0;
   logic [COEF_W-1:0]          csr_wdata = '0;

   // typed expectation travelling alongside the request payload
   bit         req_typed = 1'b0;
   result_type req_typed_result = '0;

   // filter model state and bookkeeping
   logic signed [DELAY_W-1:0] delay_model [ORDER];
   logic signed [COEF_W-1:0]  coef_b [ORDER+1];
   logic signed [COEF_W-1:0]  coef_a [ORDER+1];
   result_type                results_due [$];
   int errors = 0;
   int n_requests = 0;
   int n_results = 0;
   int n_filtered = 0;
   int n_reads = 0;
   int n_clipped = 0;
   int burst_left = 0;

   coef_set_type coef_plan [PHASES] = '{SET_FIR, SET_GENTLE, SET_EXTREME, SET_RANDOM,
                                        SET_CORNER, SET_NO_DIRECT};

   // directed requests: reset state, extremes, rounding and index corners
   dir_row_type directed_rows [DIRECTED_ROWS] = '{
      '{OP_READ,   16'sd0,        2'd0, 40'sd0,        1'b1, '{16'sd0, 1'b0, 1'b1, 40'sd0}},
      '{OP_READ,   16'sd0,        2'd3, 40'sd0,        1'b1, '{16'sd0, 1'b0, 1'b1, 40'sd0}},
      '{OP_FILTER, SAMPLE_TOP,    2'd0, 40'sd0,        1'b1, '{SAMPLE_TOP, 1'b0, 1'b0, 40'sd0}},
      '{OP_FILTER, SAMPLE_BOTTOM, 2'd0, 40'sd0,        1'b1,
        '{SAMPLE_BOTTOM, 1'b0, 1'b0, 40'sd0}},
      '{OP_NONE,   16'sh1234,     2'd1, 40'sh123456789a, 1'b0, '0},
      '{OP_WRITE,  16'sd0,        2'd0, DELAY_TOP,     1'b0, '0},
      '{OP_READ,   16'sd0,        2'd0, 40'sd0,        1'b1, '{16'sd0, 1'b0, 1'b1, DELAY_TOP}},
      '{OP_FILTER, 16'sd1,        2'd0, 40'sd0,        1'b1, '{SAMPLE_TOP, 1'b1, 1'b0, 40'sd0}},
      '{OP_WRITE,  16'sd0,        2'd1, DELAY_BOTTOM,  1'b0, '0},
      '{OP_WRITE,  16'sd0,        2'd3, 40'sd12345,    1'b0, '0},
      '{OP_READ,   16'sd0,        2'd1, 40'sd0,        1'b1,
        '{16'sd0, 1'b0, 1'b1, DELAY_BOTTOM}},
      '{OP_READ,   16'sd0,        2'd3, 40'sd0,        1'b1, '{16'sd0, 1'b0, 1'b1, 40'sd0}},
      '{OP_FILTER, -16'sd1,       2'd0, 40'sd0,        1'b1, '{-16'sd1, 1'b0, 1'b0, 40'sd0}},
      '{OP_FILTER, SAMPLE_BOTTOM, 2'd0, 40'sd0,        1'b1,
        '{SAMPLE_BOTTOM, 1'b1, 1'b0, 40'sd0}},
      '{OP_WRITE,  16'sd0,        2'd0, 40'sd8192,     1'b0, '0},
      '{OP_FILTER, 16'sd0,        2'd0, 40'sd0,        1'b1, '{16'sd1, 1'b0, 1'b0, 40'sd0}},
      '{OP_WRITE,  16'sd0,        2'd0, 40'sd8191,     1'b0, '0},
      '{OP_FILTER, 16'sd0,        2'd0, 40'sd0,        1'b1, '{16'sd0, 1'b0, 1'b0, 40'sd0}},
      '{OP_WRITE,  16'sd0,        2'd0, -40'sd8192,    1'b0, '0},
      '{OP_FILTER, 16'sd0,        2'd0, 40'sd0,        1'b1, '{16'sd0, 1'b0, 1'b0, 40'sd0}},
      '{OP_WRITE,  16'sd0,        2'd0, -40'sd8193,    1'b0, '0},
      '{OP_FILTER, 16'sd0,        2'd0, 40'sd0,        1'b1, '{-16'sd1, 1'b0, 1'b0, 40'sd0}},
      '{OP_WRITE,  16'sd0,        2'd2, 40'sh5a5a5a5a5a, 1'b0, '0},
      '{OP_FILTER, -16'sd3,       2'd0, 40'sd0,        1'b0, '0},
      '{OP_READ,   16'sd0,        2'd1, 40'sd0,        1'b0, '0}
   };

   iir_filter_transposed_df2 u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_sample        (req_sample),
      .req_state_index   (req_state_index),
      .req_state_value   (req_state_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_filtered      (rsp_filtered),
      .rsp_saturated     (rsp_saturated),
      .rsp_is_state_read (rsp_is_state_read),
      .rsp_state_read    (rsp_state_read),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // clock
   initial begin
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #5ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   // delay register clip to 40 bits
   function automatic logic signed [DELAY_W-1:0] clip_delay(input logic signed [WIDE_W-1:0] v);
      if (v > DELAY_TOP) return DELAY_TOP;
      if (v < DELAY_BOTTOM) return DELAY_BOTTOM;
      return v[DELAY_W-1:0];
   endfunction

   // one request through the filter model; returns 1 when a result is due
   function automatic bit filter_predict(input logic [OP_W-1:0] op,
                                         input logic signed [SAMPLE_W-1:0] x,
                                         input logic [IDX_W-1:0] idx,
                                         input logic signed [DELAY_W-1:0] value,
                                         output result_type r);
      logic signed [WIDE_W-1:0] acc;
      logic signed [WIDE_W-1:0] y;
      logic signed [WIDE_W-1:0] nxt;
      bit has_result;
      r = '0;
      has_result = 1'b0;
      case (op_type'(op))
         OP_FILTER: begin
            // round half up, then clip to 16 bits
            acc = delay_model[0] + coef_b[0] * x + ROUND_HALF;
            y = acc >>> FRAC_W;
            if (y > SAMPLE_TOP) begin
               y = SAMPLE_TOP;
               r.saturated = 1'b1;
            end else if (y < SAMPLE_BOTTOM) begin
               y = SAMPLE_BOTTOM;
               r.saturated = 1'b1;
            end
            r.filtered = y[SAMPLE_W-1:0];
            // ascending update, each tap from the old register above it
            for (int j = 0; j < ORDER; j++) begin
               if (j < ORDER - 1) nxt = delay_model[j+1] + coef_b[j+1] * x - coef_a[j+1] * y;
               else nxt = coef_b[j+1] * x - coef_a[j+1] * y;
               delay_model[j] = clip_delay(nxt);
            end
            has_result = 1'b1;
         end
         OP_WRITE: begin
            if (idx < ORDER) delay_model[idx] = value;
         end
         OP_READ: begin
            r.is_state_read = 1'b1;
            if (idx < ORDER) r.state_read = delay_model[idx];
            has_result = 1'b1;
         end
         default: ;
      endcase
      return has_result;
   endfunction

   task automatic report_mismatch(input string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("mismatch at result %0d: %s", n_results, msg);
   endtask

   // request/result monitor and model update
   always @(posedge clock) begin
      result_type predicted;
      result_type want;
      bit         has_result;
      if (reset) begin
         for (int j = 0; j < ORDER; j++) delay_model[j] = '0;
         for (int k = 0; k <= ORDER; k++) begin
            coef_b[k] = '0;
            coef_a[k] = '0;
         end
         coef_b[0] = COEF_ONE;
      end else begin
         if (csr_write_en && csr_index < NUM_CSR) begin
            if (csr_index < CSR_FB1) coef_b[2'(csr_index - CSR_FF0)] = csr_wdata;
            else coef_a[2'(csr_index - CSR_FB1 + CSR_W'(1))] = csr_wdata;
         end
         if (req_valid && !req_stall) begin
            n_requests++;
            has_result = filter_predict(req_op, req_sample, req_state_index, req_state_value,
                                        predicted);
            if (has_result) results_due.push_back(req_typed ? req_typed_result : predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            n_results++;
            if (results_due.size() == 0) begin
               report_mismatch("result with no request pending");
            end else begin
               want = results_due.pop_front();
               if (want.is_state_read) n_reads++;
               else n_filtered++;
               if (want.saturated) n_clipped++;
               if (rsp_filtered !== want.filtered)
                  report_mismatch($sformatf("filtered %0d, expected %0d",
                                            rsp_filtered, want.filtered));
               if (rsp_saturated !== want.saturated)
                  report_mismatch($sformatf("saturated %0b, expected %0b",
                                            rsp_saturated, want.saturated));
               if (rsp_is_state_read !== want.is_state_read)
                  report_mismatch($sformatf("is_state_read %0b, expected %0b",
                                            rsp_is_state_read, want.is_state_read));
               if (rsp_state_read !== want.state_read)
                  report_mismatch($sformatf("state_read %0d, expected %0d",
                                            rsp_state_read, want.state_read));
            end
         end
      end
   end

   // result stall pattern: open stretches, coin flips and long holds
   stall_mode_type stall_mode = STALL_NEVER;
   int             mode_left = 0;
   int             hold_left = 0;
   bit             hold_on = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         case (stall_mode)
            STALL_NEVER: rsp_stall <= 1'b0;
            STALL_COIN: rsp_stall <= ($urandom_range(0, 1) == 1);
            default: begin
               if (hold_left == 0) begin
                  hold_on = !hold_on;
                  hold_left = hold_on ? $urandom_range(5, 25) : $urandom_range(1, 6);
               end
               hold_left--;
               rsp_stall <= hold_on;
            end
         endcase
      end
   end

   // present one request and wait for it to be taken
   task automatic put_request(input logic [OP_W-1:0] op, input logic signed [SAMPLE_W-1:0] s,
                              input logic [IDX_W-1:0] idx,
                              input logic signed [DELAY_W-1:0] v,
                              input bit typed, input result_type tr);
      req_valid <= 1'b1;
      req_op <= op;
      req_sample <= s;
      req_state_index <= idx;
      req_state_value <= v;
      req_typed <= typed;
      req_typed_result <= tr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // burst pacing on the request side
   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(0, 8);
      end
   endtask

   // wait for every pending result, then let a load finish
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // stimulus
   initial begin
      logic [OP_W-1:0]            op;
      logic signed [SAMPLE_W-1:0] s;
      logic [IDX_W-1:0]           idx;
      logic signed [DELAY_W-1:0]  v;
      logic [COEF_W-1:0]          cval;
      int                         pick;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part with reset coefficients
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         put_request(directed_rows[i].op, directed_rows[i].sample, directed_rows[i].index,
                     directed_rows[i].value, directed_rows[i].typed, directed_rows[i].result);
         pace();
      end
      settle();

      // random part, one coefficient set per phase
      for (int p = 0; p < PHASES; p++) begin
         // index NUM_CSR is past the last register and must be ignored
         for (int k = 0; k <= NUM_CSR; k++) begin
            case (coef_plan[p])
               SET_FIR: cval = (k < CSR_FB1) ? COEF_W'($urandom) : '0;
               SET_GENTLE: cval = COEF_W'($urandom_range(0, 8191) - 4096);
               SET_EXTREME: cval = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
               SET_CORNER: begin
                  if (k == CSR_FF0) cval = 16'h8000;
                  else if (k == CSR_FB1) cval = 16'h7fff;
                  else cval = '0;
               end
               SET_NO_DIRECT: cval = (k == CSR_FF0) ? '0 : COEF_W'($urandom);
               default: cval = COEF_W'($urandom);
            endcase
            csr_write_en <= 1'b1;
            csr_index <= CSR_W'(k);
            csr_wdata <= cval;
            @(posedge clock);
         end
         csr_write_en <= 1'b0;
         @(posedge clock);

         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            pick = $urandom_range(0, 19);
            if (pick < 12) op = OP_FILTER;
            else if (pick < 15) op = OP_WRITE;
            else if (pick < 19) op = OP_READ;
            else op = OP_NONE;
            case ($urandom_range(0, 5))
               0: s = SAMPLE_TOP;
               1: s = SAMPLE_BOTTOM;
               2, 3: s = SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
               default: s = SAMPLE_W'($urandom);
            endcase
            idx = IDX_W'($urandom_range(0, 3));
            case ($urandom_range(0, 3))
               0: v = DELAY_TOP - DELAY_W'($urandom_range(0, 1 << 20));
               1: v = DELAY_BOTTOM + DELAY_W'($urandom_range(0, 1 << 20));
               2: v = DELAY_W'(longint'($urandom_range(0, 1 << 28)) - (longint'(1) << 27));
               default: v = DELAY_W'({$urandom, $urandom});
            endcase
            put_request(op, s, idx, v, 1'b0, '0);
            pace();
         end
         settle();
      end

      $display("%0d requests taken: %0d filtered samples (%0d clipped), %0d delay reads",
               n_requests, n_filtered, n_clipped, n_reads);
      $display("%0d coefficient sets with random request gaps and result stalls",
               PHASES + 1);
      if (errors == 0 && results_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
